// ===== hdl/fpa_pkg.sv =====
// Shared types and action codes for the fixed-point ALU.
package fpa_pkg;

  typedef enum logic [3:0] {
    ACT_ADD  = 4'd0,
    ACT_SUB  = 4'd1,
    ACT_MUL  = 4'd2,
    ACT_DIV  = 4'd3,
    ACT_GT   = 4'd4,
    ACT_LT   = 4'd5,
    ACT_GE   = 4'd6,
    ACT_LE   = 4'd7,
    ACT_EQ   = 4'd8,
    ACT_NE   = 4'd9,
    ACT_FINT = 4'd10,
    ACT_TINT = 4'd11
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  // Control that travels with each transaction down the pipeline.
  typedef struct packed {
    logic       vld;
    logic [3:0] act;
    logic       neg;
    logic       flag;
  } ctl_t;

endpackage

// ===== hdl/fixed_point_alu_q24_8.sv =====
// Every action takes the same path through the pipeline from the accepting edge to out_valid.
// Throughput: one transaction per cycle; busy is always low.
// The pipeline length is set by the divider, one quotient bit per stage over 32 + FRAC_BITS bits.
// Multiply registers a 32x32 magnitude product and rounds it in the next stage.
// Other actions ride the same delay line.
// Reset (synchronous, rst_n low) clears all valid bits; the receiver cannot stall.
module fixed_point_alu_q24_8 import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_action,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  output logic signed [31:0] out_result,
  output logic               out_flag,
  output logic [1:0]         out_status
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int ND = NW;

  // Stage 0: decode, magnitudes, simple results.
  ctl_t        c0_r;
  logic [63:0] s0_r;
  logic        ovf0_r;
  logic [31:0] ma_r, mb_r;
  logic        dz0_r;

  logic [31:0] ma_nxt, mb_nxt;
  logic signed [63:0] a64, b64, simple;
  logic        ovf_s;
  logic        flg;

  assign busy = 1'b0;

  always_comb begin
    a64 = 64'(in_operand_a);
    b64 = 64'(in_operand_b);
    ma_nxt = in_operand_a[31] ? 32'(-in_operand_a) : in_operand_a;
    mb_nxt = in_operand_b[31] ? 32'(-in_operand_b) : in_operand_b;
    simple = '0;
    flg = 1'b0;
    unique case (in_action)
      ACT_ADD:  simple = a64 + b64;
      ACT_SUB:  simple = a64 - b64;
      ACT_GT:   flg = in_operand_a > in_operand_b;
      ACT_LT:   flg = in_operand_a < in_operand_b;
      ACT_GE:   flg = in_operand_a >= in_operand_b;
      ACT_LE:   flg = in_operand_a <= in_operand_b;
      ACT_EQ:   flg = in_operand_a == in_operand_b;
      ACT_NE:   flg = in_operand_a != in_operand_b;
      ACT_FINT: simple = a64 <<< FRAC_BITS;
      ACT_TINT: simple = a64 >>> FRAC_BITS;
      default:  simple = '0;
    endcase
    ovf_s = (simple > 64'sd2147483647) || (simple < -64'sd2147483648);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r.vld <= 1'b0;
    end else begin
      c0_r.vld <= start;
    end
    c0_r.act  <= in_action;
    c0_r.neg  <= in_operand_a[31] ^ in_operand_b[31];
    c0_r.flag <= flg;
    s0_r      <= simple;
    ovf0_r    <= ovf_s;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    dz0_r     <= (in_operand_b == 32'sd0);
  end

  // Multiply: unsigned 32x32 magnitude product, registered, then round.
  logic [63:0] prod_r;
  always_ff @(posedge clk) begin
    prod_r <= 64'(ma_r) * 64'(mb_r);
  end
  logic [63:0] pround;
  assign pround = (prod_r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

  // Divider: numerator |a| << FRAC_BITS, ND bit stages.
  logic [NW-1:0] rem_w [0:ND];
  logic [NW-1:0] num_w [0:ND];
  logic [NW-1:0] quo_w [0:ND];
  logic [31:0]   den_w [0:ND];

  assign rem_w[0] = '0;
  assign num_w[0] = NW'(ma_r) << FRAC_BITS;
  assign quo_w[0] = '0;
  assign den_w[0] = mb_r;

  for (genvar g = 0; g < ND; g++) begin : g_div
    fpa_div_stage #(.NW(NW)) u_stage (
      .clk   (clk),
      .rem_i (rem_w[g]),
      .num_i (num_w[g]),
      .quo_i (quo_w[g]),
      .den_i (den_w[g]),
      .rem_o (rem_w[g+1]),
      .num_o (num_w[g+1]),
      .quo_o (quo_w[g+1]),
      .den_o (den_w[g+1])
    );
  end

  // Delay line for control and the non-divide results, ND stages after stage 0.
  ctl_t        cd_r   [0:ND-1];
  logic [63:0] sd_r   [0:ND-1];
  logic        ovfd_r [0:ND-1];
  logic        dzd_r  [0:ND-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ND; i++) cd_r[i].vld <= 1'b0;
    end else begin
      cd_r[0].vld <= c0_r.vld;
      for (int i = 1; i < ND; i++) cd_r[i].vld <= cd_r[i-1].vld;
    end
    cd_r[0].act  <= c0_r.act;
    cd_r[0].neg  <= c0_r.neg;
    cd_r[0].flag <= c0_r.flag;
    ovfd_r[0]    <= ovf0_r;
    dzd_r[0]     <= dz0_r;
    sd_r[0]      <= s0_r;
    // Multiply result replaces the simple value one stage after the product.
    sd_r[1]      <= (cd_r[0].act == ACT_MUL) ? pround : sd_r[0];
    for (int i = 1; i < ND; i++) begin
      cd_r[i].act  <= cd_r[i-1].act;
      cd_r[i].neg  <= cd_r[i-1].neg;
      cd_r[i].flag <= cd_r[i-1].flag;
      ovfd_r[i]    <= ovfd_r[i-1];
      dzd_r[i]     <= dzd_r[i-1];
    end
    for (int i = 2; i < ND; i++) begin
      sd_r[i]      <= sd_r[i-1];
    end
  end

  // Result select and status; divide rounding: round up when 2*rem >= den.
  ctl_t        cl;
  logic [NW:0] rem2;
  logic [NW:0] qr;
  logic [63:0] mag;
  logic        ovf_m;
  logic signed [31:0] res_nxt;
  logic        flag_nxt;
  logic [1:0]  st_nxt;

  always_comb begin
    cl   = cd_r[ND-1];
    rem2 = {rem_w[ND], 1'b0};
    qr   = {1'b0, quo_w[ND]} +
           (NW+1)'(rem2 >= {{(NW-31){1'b0}}, den_w[ND]});
    res_nxt  = '0;
    flag_nxt = 1'b0;
    st_nxt   = ST_OK;
    mag      = '0;
    ovf_m    = 1'b0;
    unique case (cl.act)
      ACT_ADD, ACT_SUB, ACT_FINT, ACT_TINT: begin
        if (ovfd_r[ND-1]) begin
          st_nxt = ST_OVF;
        end else begin
          res_nxt = sd_r[ND-1][31:0];
        end
      end
      ACT_MUL, ACT_DIV: begin
        if (cl.act == ACT_MUL) begin
          mag = sd_r[ND-1];
        end else begin
          mag = 64'(qr);
        end
        ovf_m = cl.neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF);
        if (cl.act == ACT_DIV && dzd_r[ND-1]) begin
          st_nxt = ST_DIV0;
        end else if (ovf_m) begin
          st_nxt = ST_OVF;
        end else begin
          res_nxt = cl.neg ? 32'(-mag[31:0]) : mag[31:0];
        end
      end
      ACT_GT, ACT_LT, ACT_GE, ACT_LE, ACT_EQ, ACT_NE: flag_nxt = cl.flag;
      default: ;
    endcase
  end

  logic               ov_r;
  logic signed [31:0] res_r;
  logic               flag_r;
  logic [1:0]         st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= cl.vld;
    end
    res_r  <= res_nxt;
    flag_r <= flag_nxt;
    st_r   <= st_nxt;
  end

  assign out_valid  = ov_r;
  assign out_result = res_r;
  assign out_flag   = flag_r;
  assign out_status = st_r;

endmodule

// ===== hdl/fpa_div_stage.sv =====
// One restoring-division step stage: one quotient bit per stage.
module fpa_div_stage import fpa_pkg::*; #(
  parameter int NW = 40
) (
  input  logic          clk,
  input  logic [NW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] quo_i,
  input  logic [31:0]   den_i,
  output logic [NW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [NW-1:0] quo_o,
  output logic [31:0]   den_o
);

  logic [NW:0] trial;
  logic [NW:0] diff;

  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    diff  = trial - {{(NW-31){1'b0}}, den_i};
  end

  always_ff @(posedge clk) begin
    if (!diff[NW]) begin
      rem_o <= diff[NW-1:0];
    end else begin
      rem_o <= trial[NW-1:0];
    end
    quo_o <= {quo_i[NW-2:0], ~diff[NW]};
    num_o <= {num_i[NW-2:0], 1'b0};
    den_o <= den_i;
  end

endmodule
